// ===== sv/sp2c_pkg.sv =====
package sp2c_pkg;

  // Scan geometry and CORDIC depth.
  localparam int BEAM_COUNT    = 1024;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int STG_IDX_W     = $clog2(ATAN_ENTRIES);

  // Inverse CORDIC gain in Q24.
  localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
  localparam int          EXTRA_BITS   = 8;

  // Datapath widths: x/y carry 8 extra fraction bits, z is in pi/2^24 units.
  localparam int XW = 27;
  localparam int ZW = 27;

  // Configuration register indexes.
  localparam int          CFG_IDX_W         = 2;
  localparam logic [1:0]  CFG_ANGLE_STEP    = 2'd0;
  localparam logic [1:0]  CFG_ANGLE_OFFSET  = 2'd1;
  localparam logic [1:0]  CFG_FORWARD_OFFSET = 2'd2;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // round(atan(2^-i) * 2^24 / pi)
  function automatic logic [ZW-1:0] atan_val(input logic [STG_IDX_W-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(4194304);
      5'd1:    v = ZW'(2476042);
      5'd2:    v = ZW'(1308273);
      5'd3:    v = ZW'(664100);
      5'd4:    v = ZW'(333339);
      5'd5:    v = ZW'(166832);
      5'd6:    v = ZW'(83436);
      5'd7:    v = ZW'(41721);
      5'd8:    v = ZW'(20861);
      5'd9:    v = ZW'(10430);
      5'd10:   v = ZW'(5215);
      5'd11:   v = ZW'(2608);
      5'd12:   v = ZW'(1304);
      5'd13:   v = ZW'(652);
      5'd14:   v = ZW'(326);
      5'd15:   v = ZW'(163);
      5'd16:   v = ZW'(81);
      5'd17:   v = ZW'(41);
      5'd18:   v = ZW'(20);
      5'd19:   v = ZW'(10);
      5'd20:   v = ZW'(5);
      5'd21:   v = ZW'(3);
      5'd22:   v = ZW'(1);
      5'd23:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/sp2c_cordic_stage.sv =====
module sp2c_cordic_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sp2c_pkg::STG_IDX_W-1:0]      stage_idx,
  input  logic [sp2c_pkg::ZW-1:0]             atan_step,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sp2c_pkg::vec_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sp2c_pkg::vec_t                      out_data
);

  logic            valid_r;
  sp2c_pkg::vec_t  data_r;
  sp2c_pkg::vec_t  data_nxt;
  logic signed [sp2c_pkg::XW-1:0] dx;
  logic signed [sp2c_pkg::XW-1:0] dy;
  logic signed [sp2c_pkg::ZW-1:0] da;

  // Rotate toward zero residual angle; shifts floor toward minus infinity.
  always_comb begin
    dx = in_data.y >>> stage_idx;
    dy = in_data.x >>> stage_idx;
    da = $signed(atan_step);
    if (!in_data.z[sp2c_pkg::ZW-1]) begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - da;
    end else begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + da;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== sv/scan_polar_to_cartesian.sv =====
// Converts laser scan beams to Cartesian points. Each input transaction carries one
// beam; beams flagged invalid, equal to their reference range, or with an index past
// the scan produce no output transaction. The beam angle is
// beam_index * angle_step + angle_offset (16-bit binary angle, pi/32768 units), and
// the range is rotated by a pipelined CORDIC to give point_x = r*cos + forward_offset
// and point_y = r*sin, both saturated to their field widths. The pipeline takes one
// beam per clock unless held off by an output stall, and its register stages are:
// one stage for the angle and gain multiplies, one for quadrant folding, one
// per CORDIC iteration and one for rounding and saturation. Every stage has its own
// valid bit and hold logic, so stalls on the output fill empty stages before the
// input is held off. Configuration writes are always accepted and must be issued
// while no beam is in flight.
module scan_polar_to_cartesian (
  input  logic        clk,
  input  logic        rst_n,
  // Beam input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // beam_index[9:0], range_value[25:10],
                                  // reference_range[41:26], zero[47:42]
  input  logic        in_tuser,   // range_invalid
  // Point output.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // point_x[17:0], point_y[34:18], zero[39:35]
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int XW = sp2c_pkg::XW;
  localparam int ZW = sp2c_pkg::ZW;
  localparam int NS = sp2c_pkg::NUM_STAGES;

  // Configuration registers.
  logic [15:0] angle_step_r;
  logic [15:0] angle_offset_r;
  logic [15:0] forward_offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_step_r     <= '0;
      angle_offset_r   <= '0;
      forward_offset_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sp2c_pkg::CFG_ANGLE_STEP:     angle_step_r     <= cfg_data;
        sp2c_pkg::CFG_ANGLE_OFFSET:   angle_offset_r   <= cfg_data;
        sp2c_pkg::CFG_FORWARD_OFFSET: forward_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input field unpacking.
  logic [9:0]  in_beam_index;
  logic [15:0] in_range_value;
  logic [15:0] in_reference_range;
  logic        in_accept;
  logic        in_keep;

  assign in_beam_index      = in_tdata[9:0];
  assign in_range_value     = in_tdata[25:10];
  assign in_reference_range = in_tdata[41:26];
  assign in_accept          = in_tvalid && in_tready;
  assign in_keep = !in_tuser && (in_range_value != in_reference_range) &&
                   (32'(in_beam_index) < 32'(sp2c_pkg::BEAM_COUNT));

  // Stage 1: beam angle and gain-compensated range product.
  logic        s1_vld_r;
  logic [15:0] s1_angle_r;
  logic [39:0] s1_prod_r;
  logic [15:0] s1_angle_nxt;
  logic [25:0] ang_mult;
  logic        s1_ready;

  assign ang_mult     = 26'(in_beam_index) * 26'(angle_step_r);
  assign s1_angle_nxt = ang_mult[15:0] + angle_offset_r;
  assign in_tready    = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= in_accept && in_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_angle_r <= s1_angle_nxt;
      s1_prod_r  <= 40'(in_range_value) * 40'(sp2c_pkg::INV_GAIN_Q24);
    end
  end

  // Stage 2: round the scaled range and fold angles of a quarter turn or more
  // back into the right half plane by negating the start vector.
  logic            s2_vld_r;
  sp2c_pkg::vec_t  s2_vec_r;
  sp2c_pkg::vec_t  s2_vec_nxt;
  logic            s2_ready;
  logic [40:0]     prod_rnd;
  logic [24:0]     x_mag;
  logic            fold;
  logic [15:0]     ang_fold;

  assign prod_rnd = {1'b0, s1_prod_r} + 41'd32768;
  assign x_mag    = prod_rnd[40:16];
  assign fold     = s1_angle_r[15] ^ s1_angle_r[14];
  assign ang_fold = fold ? {~s1_angle_r[15], s1_angle_r[14:0]} : s1_angle_r;

  always_comb begin
    s2_vec_nxt.x = fold ? -$signed(XW'(x_mag)) : $signed(XW'(x_mag));
    s2_vec_nxt.y = '0;
    s2_vec_nxt.z = $signed({{(ZW-25){ang_fold[15]}}, ang_fold, 9'b0});
  end

  assign s1_ready = !s1_vld_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_vld_r) begin
      s2_vec_r <= s2_vec_nxt;
    end
  end

  // CORDIC rotation stages, one iteration per register stage.
  logic           st_valid [0:NS];
  logic           st_ready [0:NS];
  sp2c_pkg::vec_t st_data  [0:NS];

  assign st_valid[0] = s2_vld_r;
  assign st_data[0]  = s2_vec_r;
  assign s2_ready    = !s2_vld_r || st_ready[0];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    sp2c_cordic_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (sp2c_pkg::STG_IDX_W'(g)),
      .atan_step (sp2c_pkg::atan_val(sp2c_pkg::STG_IDX_W'(g))),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  // Output stage: drop the extra fraction bits with rounding, add the mounting
  // offset to x and saturate both coordinates.
  localparam int RW = XW - sp2c_pkg::EXTRA_BITS;
  logic signed [XW-1:0] x_rnd;
  logic signed [XW-1:0] y_rnd;
  logic signed [RW-1:0] x_sh;
  logic signed [RW-1:0] y_sh;
  logic signed [RW:0]   px_sum;
  logic [17:0]          px_sat;
  logic [16:0]          py_sat;
  logic                 out_vld_r;
  logic [17:0]          point_x_r;
  logic [16:0]          point_y_r;
  logic                 out_ready_int;

  always_comb begin
    x_rnd  = st_data[NS].x + XW'(128);
    y_rnd  = st_data[NS].y + XW'(128);
    x_sh   = RW'(x_rnd >>> sp2c_pkg::EXTRA_BITS);
    y_sh   = RW'(y_rnd >>> sp2c_pkg::EXTRA_BITS);
    px_sum = (RW+1)'(x_sh) + (RW+1)'($signed(forward_offset_r));
    if (px_sum > (RW+1)'(131071)) begin
      px_sat = 18'h1FFFF;
    end else if (px_sum < -(RW+1)'(131072)) begin
      px_sat = 18'h20000;
    end else begin
      px_sat = px_sum[17:0];
    end
    if (y_sh > RW'(65535)) begin
      py_sat = 17'h0FFFF;
    end else if (y_sh < -RW'(65536)) begin
      py_sat = 17'h10000;
    end else begin
      py_sat = y_sh[16:0];
    end
  end

  assign out_ready_int = !out_vld_r || out_tready;
  assign st_ready[NS]  = out_ready_int;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ready_int) begin
      out_vld_r <= st_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_int && st_valid[NS]) begin
      point_x_r <= px_sat;
      point_y_r <= py_sat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, point_y_r, point_x_r};

  // A beam flagged invalid never enters the datapath.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser) |=> !s1_vld_r)
    else $error("invalid beam entered the pipeline");

  // A beam equal to its reference range never enters the datapath.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_range_value == in_reference_range)) |=> !s1_vld_r)
    else $error("reference beam entered the pipeline");

  // After folding, the start angle lies within a quarter turn.
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_vec_r.z <= $signed(ZW'(8388096)) &&
                  s2_vec_r.z >= -$signed(ZW'(8388608))))
    else $error("folded angle outside a quarter turn");

  // The first stage register holds a valid beam while the next stage cannot take it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s2_ready) |=> (s1_vld_r && $stable(s1_angle_r)))
    else $error("stage one lost a held beam");

endmodule
